@@ rtl/crf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package crf_pkg;

    // Operation codes carried in the func field
    localparam logic [2:0] FUNC_ENQUEUE = 3'd0;
    localparam logic [2:0] FUNC_START   = 3'd1;
    localparam logic [2:0] FUNC_DISCARD = 3'd2;
    localparam logic [2:0] FUNC_DEQUEUE = 3'd3;
    localparam logic [2:0] FUNC_GET     = 3'd4;

    // Result status codes
    localparam logic [1:0] STAT_OK         = 2'd0;
    localparam logic [1:0] STAT_VIEW_EMPTY = 2'd1;
    localparam logic [1:0] STAT_LIVE_EMPTY = 2'd2;
    localparam logic [1:0] STAT_RING_FULL  = 2'd3;

    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] frame_word;
    } t_in_item;

    typedef struct packed {
        logic [31:0] read_word;
        logic [1:0]  status;
        logic [4:0]  live_count;
        logic [4:0]  saved_count;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FIN
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic finish;
    } t_dp_cmd;

endpackage

`default_nettype wire

@@ rtl/crf_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module crf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/crf_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module crf_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    output logic                 o_busy,
    output crf_pkg::t_dp_cmd     o_cmd
);

    crf_pkg::t_state r_state;
    crf_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= crf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd.load   = 1'b0;
        o_cmd.exec   = 1'b0;
        o_cmd.finish = 1'b0;
        o_busy       = 1'b1;
        case (r_state)
            crf_pkg::ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = crf_pkg::ST_EXEC;
                end
            end
            crf_pkg::ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = crf_pkg::ST_FIN;
            end
            crf_pkg::ST_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = crf_pkg::ST_IDLE;
            end
            default: begin
                n_state = crf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/crf_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module crf_datapath #(
    parameter int DEPTH      = 16,
    parameter int WORD_WIDTH = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire crf_pkg::t_dp_cmd  i_cmd,
    input  wire crf_pkg::t_in_item i_item,
    output crf_pkg::t_out_item     o_result,
    output logic                   o_done
);

    localparam int AW = $clog2(DEPTH);
    localparam int PW = $clog2(2 * DEPTH);
    localparam logic [PW-1:0] DEPTH_P  = PW'(DEPTH);
    localparam logic [PW-1:0] PTR_LAST = PW'(2 * DEPTH - 1);
    localparam logic [PW:0]   TWO_D    = (PW + 1)'(2 * DEPTH);

    // Entries between a head and the tail, pointers modulo twice the depth
    function automatic logic [PW-1:0] view_cnt(input logic [PW-1:0] tail,
                                               input logic [PW-1:0] head);
        logic [PW:0] sum;
        sum = {1'b0, tail} - {1'b0, head};
        if (tail < head) begin
            sum = sum + TWO_D;
        end
        return sum[PW-1:0];
    endfunction

    function automatic logic [AW-1:0] ring_idx(input logic [PW-1:0] ptr);
        logic [PW-1:0] red;
        red = (ptr >= DEPTH_P) ? (ptr - DEPTH_P) : ptr;
        return red[AW-1:0];
    endfunction

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] ptr);
        return (ptr == PTR_LAST) ? '0 : ptr + PW'(1);
    endfunction

    logic [2:0]            r_func;
    logic [31:0]           r_word;
    logic [PW-1:0]         r_tail, r_live, r_saved;
    logic [PW-1:0]         n_tail, n_live, n_saved;
    logic [1:0]            r_status, n_status;
    logic                  r_rd_ok, n_rd_ok;
    crf_pkg::t_out_item    r_result;
    logic                  r_done;

    logic [PW-1:0]         live_cnt, saved_cnt, used_cnt;
    logic                  ram_we, ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [WORD_WIDTH-1:0] ram_wdata, ram_rdata;
    logic [63:0]           word_ext, rdata_ext;

    assign live_cnt  = view_cnt(r_tail, r_live);
    assign saved_cnt = view_cnt(r_tail, r_saved);
    assign used_cnt  = (live_cnt > saved_cnt) ? live_cnt : saved_cnt;
    assign word_ext  = 64'(r_word);
    assign ram_wdata = word_ext[WORD_WIDTH-1:0];
    assign rdata_ext = 64'(ram_rdata);

    // Decode the held operation and work out the pointer moves
    always_comb begin
        n_tail    = r_tail;
        n_live    = r_live;
        n_saved   = r_saved;
        n_status  = crf_pkg::STAT_OK;
        n_rd_ok   = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = ring_idx(r_live);
        case (r_func)
            crf_pkg::FUNC_ENQUEUE: begin
                if (live_cnt == '0) begin
                    n_status = crf_pkg::STAT_LIVE_EMPTY;
                end else if (used_cnt >= DEPTH_P) begin
                    n_status = crf_pkg::STAT_RING_FULL;
                end else begin
                    ram_we = 1'b1;
                    n_tail = ptr_inc(r_tail);
                end
            end
            crf_pkg::FUNC_START: begin
                n_saved = r_tail;
                if (live_cnt >= DEPTH_P) begin
                    n_status = crf_pkg::STAT_RING_FULL;
                end else begin
                    ram_we = 1'b1;
                    n_tail = ptr_inc(r_tail);
                end
            end
            crf_pkg::FUNC_DISCARD: begin
                n_live = r_saved;
            end
            crf_pkg::FUNC_DEQUEUE: begin
                if (live_cnt == '0) begin
                    n_status = crf_pkg::STAT_VIEW_EMPTY;
                end else begin
                    ram_re  = 1'b1;
                    n_rd_ok = 1'b1;
                    n_live  = ptr_inc(r_live);
                end
            end
            crf_pkg::FUNC_GET: begin
                ram_raddr = ring_idx(r_saved);
                if (saved_cnt == '0) begin
                    n_status = crf_pkg::STAT_VIEW_EMPTY;
                end else begin
                    ram_re  = 1'b1;
                    n_rd_ok = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    crf_ram #(
        .WIDTH (WORD_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we && i_cmd.exec),
        .i_waddr (ring_idx(r_tail)),
        .i_wdata (ram_wdata),
        .i_re    (ram_re && i_cmd.exec),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_item.func;
            r_word <= i_item.frame_word;
        end
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_rd_ok  <= n_rd_ok;
        end
        if (i_cmd.finish) begin
            r_result.read_word   <= r_rd_ok ? rdata_ext[31:0] : '0;
            r_result.status      <= r_status;
            r_result.live_count  <= 5'(live_cnt);
            r_result.saved_count <= 5'(saved_cnt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail  <= '0;
            r_live  <= '0;
            r_saved <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= i_cmd.finish;
            if (i_cmd.exec) begin
                r_tail  <= n_tail;
                r_live  <= n_live;
                r_saved <= n_saved;
            end
        end
    end

    assign o_result = r_result;
    assign o_done   = r_done;

endmodule

`default_nettype wire

@@ rtl/checkpoint_rollback_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Checkpoint FIFO: one ring of DEPTH words with a tail and two heads.
// The live head is the normal queue; the saved head marks the words pushed
// since the last start operation, so a discard rolls the live view back.
//
// Input channel: drive i_item (func, frame_word) and raise start while busy
// is low; the item is taken at that clock edge. busy stays high while the
// operation runs.
// Result channel: o_result (read_word, status, live_count, saved_count) is
// valid for exactly one cycle with o_done high, once the finish step has
// registered it. The receiver cannot hold results off, and none is needed:
// one item is in flight at a time.
// Each item passes a load cycle, an execute cycle that moves the pointers and
// makes at most one ring access (a write, or a read on the RAM's registered
// port), and a finish cycle that captures the read data and the view counts
// into the result register. No new item is taken before the finish cycle.
// Reset (i_rst_n low, synchronous): all pointers go to zero, both views
// empty, no result pending. The ring contents are not cleared.
module checkpoint_rollback_fifo #(
    parameter int DEPTH      = 16,
    parameter int WORD_WIDTH = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire crf_pkg::t_in_item i_item,
    output crf_pkg::t_out_item     o_result,
    output logic                   o_done
);

    crf_pkg::t_dp_cmd cmd;

    // Sequence load, execute, finish for each item
    crf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    // Hold pointers, ring and result register
    crf_datapath #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_item   (i_item),
        .o_result (o_result),
        .o_done   (o_done)
    );

endmodule

`default_nettype wire

@@ rtl/crf_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module crf_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire crf_pkg::t_out_item o_result,
    input wire logic               o_done
);

    // Every accepted item produces a result strobe on o_done
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##3 o_done)
        else $error("accepted item produced no result on time");

    // An accepted item keeps the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accept");

    // No result is shown while an operation is still running
    a_no_done_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !o_done)
        else $error("result strobe while busy");

    // A failed operation returns a zero word
    a_zero_word_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_result.status != crf_pkg::STAT_OK) |-> o_result.read_word == '0)
        else $error("nonzero read word with error status");

endmodule

bind checkpoint_rollback_fifo crf_checker u_crf_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_result (o_result),
    .o_done   (o_done)
);

`default_nettype wire
